### hdl/nearest_neighbor_image_scaler_macros.svh
// Assertion macros used by the scaler RTL
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH
// Implication checked every clock, disabled in reset
`define NNS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled in reset
`define NNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### hdl/nns_pkg.sv
// Shared types and constants of the nearest-neighbor scaler
package nns_pkg;
   localparam int unsigned FUNC_W   = 1;
   localparam int unsigned COORD_W  = 10;
   localparam int unsigned PIX_W    = 32;
   localparam int unsigned SW_W     = 9;
   localparam int unsigned EW_W     = 11;
   localparam int unsigned BPP_W    = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 11;
   localparam int unsigned QUO_W    = 11;

   // Frame and destination size limits
   localparam int unsigned MAX_SRC_WIDTH  = 256;
   localparam int unsigned MAX_SRC_HEIGHT = 256;
   localparam int unsigned MAX_DST_WIDTH  = 1024;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_STORE = 1'b0,
      FUNC_READ  = 1'b1
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_W  = 3'd0,
      REG_SRC_H  = 3'd1,
      REG_DST_W  = 3'd2,
      REG_DST_H  = 3'd3,
      REG_BPP    = 3'd4
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVX,
      ST_DIVY,
      ST_DONE
   } div_state_type;

   // Classified item passed from front to back
   typedef struct packed {
      func_type               func;
      logic                   err;
      logic [COORD_W-1:0]     col;
      logic [COORD_W-1:0]     row;
      logic [PIX_W-1:0]       pixel;
      logic [31:0]            bmask;
   } item_type;

   // Effective geometry
   typedef struct packed {
      logic [SW_W-1:0] sw;
      logic [SW_W-1:0] sh;
      logic [SW_W-1:0] eh;
      logic [EW_W-1:0] ew;
   } geom_type;

   function automatic logic [31:0] byte_mask(input logic [BPP_W-1:0] bpp);
      logic [31:0] m;
      begin
         case (bpp)
            3'd0, 3'd1: m = 32'h0000_00FF;
            3'd2:       m = 32'h0000_FFFF;
            3'd3:       m = 32'h00FF_FFFF;
            default:    m = 32'hFFFF_FFFF;
         endcase
         return m;
      end
   endfunction
endpackage

### hdl/nearest_neighbor_image_scaler.sv
// Top level of the nearest-neighbor image scaler
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_tvalid/tready  | tdata: col, row, pixel_in; tuser: func
//  rsp_    | out       | rsp_tvalid/tready  | tdata: pixel_out, eff_width, eff_height,
//          |           |                    |        error
//  csr_    | in        | csr_wr_en          | csr_index, csr_wdata
//
// A store or an out-of-range item goes to the result without the divider.
// A read makes two passes through the 21-step serial divider (source column,
// then source row) and one frame-store read.
// Reset is synchronous and clears control only; the frame store is not cleared.
// After a size register changes, req_tready is held low while the
// derived width settles.
// The request queue holds two items, so up to two requests still transfer
// while a result waits on rsp_tready.
module nearest_neighbor_image_scaler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,  // col[9:0], row[19:10], pixel_in[51:20], zero pad
   input  logic [0:0]   req_tuser,  // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,  // pixel_out[31:0], eff_width[42:32],
                                    // eff_height[51:43], error[52], zero pad
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [10:0]  csr_wdata
);
   import nns_pkg::*;

   logic [SW_W-1:0]  src_w_ff, src_h_ff;
   logic [EW_W-1:0]  dst_w_ff, dst_h_ff;
   logic [BPP_W-1:0] bpp_ff;
   geom_type         geom;
   logic [SW_W-1:0]  sw, sh, eh;
   logic [EW_W-1:0]  dh_nz;
   logic [17:0]      eh_sw;
   logic [EW_W-1:0]  ew_calc_ff;
   logic             q_valid, q_ready;
   item_type         q_item;
   logic [PIX_W-1:0] pix;
   logic             err;
   logic             ew_ok, front_ready;

   // hold the registers; writes must arrive only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 9'd256;
         src_h_ff <= 9'd256;
         dst_w_ff <= 11'd0;
         dst_h_ff <= 11'd256;
         bpp_ff   <= 3'd4;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SRC_W: src_w_ff <= csr_wdata[SW_W-1:0];
            REG_SRC_H: src_h_ff <= csr_wdata[SW_W-1:0];
            REG_DST_W: dst_w_ff <= csr_wdata;
            REG_DST_H: dst_h_ff <= csr_wdata;
            REG_BPP:   bpp_ff   <= csr_wdata[BPP_W-1:0];
            default: ;
         endcase
      end
   end

   // saturate and clamp sizes
   always_comb begin
      sw = (src_w_ff == '0) ? SW_W'(1) :
           ({23'd0, src_w_ff} > MAX_SRC_WIDTH) ? SW_W'(MAX_SRC_WIDTH) : src_w_ff;
      sh = (src_h_ff == '0) ? SW_W'(1) :
           ({23'd0, src_h_ff} > MAX_SRC_HEIGHT) ? SW_W'(MAX_SRC_HEIGHT) : src_h_ff;
      dh_nz = (dst_h_ff == '0) ? EW_W'(1) : dst_h_ff;
      eh = (dh_nz > {2'b00, sh}) ? sh : dh_nz[SW_W-1:0];
      eh_sw = 18'(eh) * 18'(sw);
      geom.sw = sw;
      geom.sh = sh;
      geom.eh = eh;
      geom.ew = (dst_w_ff == '0) ? ew_calc_ff :
                ({21'd0, dst_w_ff} > MAX_DST_WIDTH) ? EW_W'(MAX_DST_WIDTH) : dst_w_ff;
   end

   // derived width: eh*sw/sh with sh a config value; a small restoring
   // divide restarts whenever its operands change
   logic [17:0]     dq_ff, dq_in;
   logic [SW_W:0]   dr_ff, dr_in;
   logic [SW_W+1:0] dt;
   logic [4:0]      dc_ff, dc_in;
   logic [17:0]     src_key_ff;
   logic [SW_W-1:0] sh_key_ff;

   always_comb begin
      dq_in = dq_ff;
      dr_in = dr_ff;
      dc_in = dc_ff;
      dt    = '0;
      if (eh_sw != src_key_ff || sh != sh_key_ff) begin
         dq_in = eh_sw;
         dr_in = '0;
         dc_in = 5'd18;
      end else if (dc_ff != 5'd0) begin
         dt = {dr_ff, dq_ff[17]} - {2'b00, sh};
         if (!dt[SW_W+1]) begin
            dr_in = dt[SW_W:0];
            dq_in = {dq_ff[16:0], 1'b1};
         end else begin
            dr_in = {dr_ff[SW_W-1:0], dq_ff[17]};
            dq_in = {dq_ff[16:0], 1'b0};
         end
         dc_in = dc_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff      <= 5'd0;
         src_key_ff <= 18'd65536;
         sh_key_ff  <= 9'd256;
         dq_ff      <= 18'd256;
         ew_calc_ff <= 11'd256;
      end else begin
         dc_ff      <= dc_in;
         src_key_ff <= eh_sw;
         sh_key_ff  <= sh;
         dq_ff      <= dq_in;
         if (dc_ff == 5'd1) begin
            ew_calc_ff <= dq_in[EW_W-1:0];
         end
      end
      dr_ff <= dr_in;
   end

   // hold requests until the derived width has settled
   assign ew_ok      = (dc_ff == 5'd0) && (eh_sw == src_key_ff) && (sh == sh_key_ff);
   assign req_tready = front_ready && ew_ok;

   nns_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid && ew_ok),
      .in_ready (front_ready),
      .in_func  (req_tuser),
      .in_col   (req_tdata[9:0]),
      .in_row   (req_tdata[19:10]),
      .in_pixel (req_tdata[51:20]),
      .geom     (geom),
      .bpp      (bpp_ff),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item)
   );

   nns_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .geom      (geom),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (pix),
      .out_err   (err)
   );

   assign rsp_tdata = {3'b000, err, geom.eh, geom.ew, pix};
endmodule

### hdl/nns_ram.sv
// Generic single-port write, single-port registered-read RAM
module nns_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end
   assign rd_data = rd_data_ff;
endmodule

### hdl/nns_divider.sv
// Iterative restoring divider, one quotient bit per cycle
module nns_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [20:0]               dividend,
   input  logic [nns_pkg::EW_W-1:0]  divisor,
   output logic                      done,
   output logic [nns_pkg::QUO_W-1:0] quotient
);
   import nns_pkg::*;
   localparam int unsigned STEPS = 21;
   localparam int unsigned CNT_W = $clog2(STEPS + 1);

   logic [20:0]      quo_ff, quo_in;
   logic [EW_W:0]    rem_ff, rem_in;
   logic [EW_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [EW_W+1:0]  trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit into the remainder, try a subtract
         trial = {rem_ff, quo_ff[20]} - {2'b00, dvs_ff};
         if (!trial[EW_W+1]) begin
            rem_in = trial[EW_W:0];
            quo_in = {quo_ff[19:0], 1'b1};
         end else begin
            rem_in = {rem_ff[EW_W-1:0], quo_ff[20]};
            quo_in = {quo_ff[19:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[QUO_W-1:0];
endmodule

### hdl/nns_front.sv
// Front end: capture requests, check bounds and classify into the queue
module nns_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [nns_pkg::FUNC_W-1:0]  in_func,
   input  logic [nns_pkg::COORD_W-1:0] in_col,
   input  logic [nns_pkg::COORD_W-1:0] in_row,
   input  logic [nns_pkg::PIX_W-1:0]   in_pixel,
   input  nns_pkg::geom_type           geom,
   input  logic [nns_pkg::BPP_W-1:0]   bpp,
   output logic                        q_valid,
   input  logic                        q_ready,
   output nns_pkg::item_type           q_item
);
   import nns_pkg::*;
   localparam int unsigned DEPTH = 2;

   item_type   slot_ff [DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   cls;
   logic       push, pop;

   always_comb begin
      cls.func  = func_type'(in_func);
      cls.col   = in_col;
      cls.row   = in_row;
      cls.pixel = in_pixel;
      cls.bmask = byte_mask(bpp);
      if (in_func == FUNC_STORE) begin
         cls.err = ({1'b0, in_col} >= {2'b00, geom.sw}) ||
                   ({1'b0, in_row} >= {2'b00, geom.sh});
      end else begin
         cls.err = ({1'b0, in_col} >= geom.ew) ||
                   ({1'b0, in_row} >= {2'b00, geom.eh});
      end
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_item   = slot_ff[rp_ff];
   assign wp_in    = push ? ~wp_ff : wp_ff;
   assign rp_in    = pop ? ~rp_ff : rp_ff;
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= cls;
      end
   end
endmodule

### hdl/nns_back.sv
// Back end: divide, access the frame store, drive the result register
module nns_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  nns_pkg::item_type             q_item,
   input  nns_pkg::geom_type             geom,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [nns_pkg::PIX_W-1:0]     out_pixel,
   output logic                          out_err
);
   import nns_pkg::*;
   `include "nearest_neighbor_image_scaler_macros.svh"

   div_state_type   st_ff, st_in;
   item_type        it_ff, it_in;
   logic [SW_W-1:0] sx_ff, sx_in;
   logic            ov_ff, ov_in;
   logic [PIX_W-1:0] op_ff, op_in;
   logic            oe_ff, oe_in;
   logic            rd_pend_ff, rd_pend_in;
   logic            div_start, div_done;
   logic [20:0]     dividend;
   logic [EW_W-1:0] divisor;
   logic [QUO_W-1:0] quo;
   logic            wr_en, rd_en;
   logic [15:0]     wr_addr, rd_addr;
   logic [PIX_W-1:0] rd_data;

   nns_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quo)
   );

   nns_ram #(.WIDTH(PIX_W), .DEPTH(65536)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (it_ff.pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_addr = {it_ff.row[7:0], it_ff.col[7:0]};
   assign rd_addr = {quo[7:0], sx_ff[7:0]};

   always_comb begin
      st_in      = st_ff;
      it_in      = it_ff;
      sx_in      = sx_ff;
      ov_in      = ov_ff;
      op_in      = op_ff;
      oe_in      = oe_ff;
      rd_pend_in = 1'b0;
      q_ready    = 1'b0;
      div_start  = 1'b0;
      dividend   = '0;
      divisor    = '0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      if (ov_ff && out_ready) begin
         ov_in = 1'b0;
      end
      unique case (st_ff)
         ST_IDLE: begin
            // take a new item only once the result register is free
            q_ready = !ov_in;
            if (q_valid && !ov_in) begin
               it_in = q_item;
               if (q_item.err || q_item.func == FUNC_STORE) begin
                  st_in = ST_DONE;
               end else begin
                  div_start = 1'b1;
                  dividend  = 21'(q_item.col) * 21'(geom.sw);
                  divisor   = geom.ew;
                  st_in     = ST_DIVX;
               end
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               sx_in     = quo[SW_W-1:0];
               div_start = 1'b1;
               dividend  = 21'(it_ff.row) * 21'(geom.sh);
               divisor   = {2'b00, geom.eh};
               st_in     = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               st_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (it_ff.func == FUNC_STORE && !it_ff.err) begin
               wr_en = 1'b1;
            end
            if (rd_pend_ff) begin
               op_in = rd_data & it_ff.bmask;
            end else begin
               op_in = '0;
            end
            oe_in = it_ff.err;
            ov_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         ov_ff      <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         ov_ff      <= ov_in;
         rd_pend_ff <= rd_pend_in;
      end
      it_ff <= it_in;
      sx_ff <= sx_in;
      op_ff <= op_in;
      oe_ff <= oe_in;
   end

   assign out_valid = ov_ff;
   assign out_pixel = op_ff;
   assign out_err   = oe_ff;

   `NNS_ASSERT_NEXT(a_hold_result, clock, reset, ov_ff && !out_ready, ov_ff, "result dropped")
   `NNS_ASSERT_IMPL(a_no_wr_on_err, clock, reset, wr_en, !it_ff.err, "write on error")
   `NNS_ASSERT_IMPL(a_rd_from_div, clock, reset, rd_en, st_ff == ST_DIVY, "stray read")
   `NNS_ASSERT_IMPL(a_done_only, clock, reset, ov_ff && !$past(ov_ff), $past(st_ff) == ST_DONE,
                    "result without item")
endmodule
